// ===== rtl/memory_type_range_table_defines.svh =====
// Assertion macros for the memory type range table.
// Included by the RTL modules that carry concurrent checks; no other dependencies.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef MEMORY_TYPE_RANGE_TABLE_DEFINES_SVH
`define MEMORY_TYPE_RANGE_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define MTRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MTRT_ASSERT_IMP(lbl, ante, cons, msg)
`define MTRT_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/mtrt_pkg.sv =====
// Shared types and constants for the memory type range table.
// No dependencies; imported by the controller, the datapath and the top level.
package mtrt_pkg;

  localparam int NUM_RANGES    = 8;
  localparam int ADDR_BITS     = 52;
  localparam int SIZE_BITS     = ADDR_BITS + 1;
  localparam int MIN_SIZE_LOG2 = 12;
  localparam int IDX_W         = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
  localparam int LOG2_W        = 6;
  localparam int SLOT_W        = 3;
  localparam int STATUS_W      = 3;
  localparam int MTYPE_W       = 8;
  localparam int ETYPE_W       = 3;
  localparam int RANGES_W      = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 8;

  localparam logic [MTYPE_W-1:0]  TYPE_MAX         = 8'h06;
  localparam logic [MTYPE_W-1:0]  DEFAULT_TYPE_RST = 8'h06;
  localparam logic [RANGES_W-1:0] RANGES_RST       = 4'd8;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_READY = 3'd1,
    ST_BAD_PARAM = 3'd2,
    ST_NO_SLOT   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_READY        = 2'd0,
    CFG_DEFAULT_TYPE = 2'd1,
    CFG_RANGES       = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

// ===== rtl/mtrt_ctrl.sv =====
// Controller state machine for the memory type range table.
// Depends on mtrt_pkg and memory_type_range_table_defines.svh.
`include "memory_type_range_table_defines.svh"

module mtrt_ctrl
  import mtrt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    busy        = 1'b0;
    case (state_r)
      S_IDLE: begin
        cmd.capture = start;
      end
      S_EXEC: begin
        cmd.execute = 1'b1;
        busy        = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  `MTRT_ASSERT_NXT(a_capture_then_exec, cmd.capture, cmd.execute && busy,
    "capture not followed by execute")
  `MTRT_ASSERT_NXT(a_exec_one_cycle, cmd.execute, !cmd.execute && !busy,
    "execute lasted more than one cycle")
  `MTRT_ASSERT_IMP(a_accept_captures, start && !busy, cmd.capture,
    "accepted word was not captured")

endmodule

// ===== rtl/mtrt_dp.sv =====
// Datapath of the memory type range table: configuration registers, request
// capture, the range table with parallel comparators, and the result registers.
// Depends on mtrt_pkg and memory_type_range_table_defines.svh.
`include "memory_type_range_table_defines.svh"

module mtrt_dp
  import mtrt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  input  logic [1:0]            in_op,
  input  logic [ADDR_BITS-1:0]  in_address,
  input  logic [SIZE_BITS-1:0]  in_size,
  input  logic [MTYPE_W-1:0]    in_mem_type,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic [MTYPE_W-1:0]    out_found_type,
  output logic [SLOT_W-1:0]     out_slot
);

  // Lowest set bit of a hit vector.
  function automatic logic [IDX_W:0] pick_first(input logic [NUM_RANGES-1:0] hits);
    logic [IDX_W:0] res;
    res = '0;
    for (int i = NUM_RANGES - 1; i >= 0; i--) begin
      if (hits[i]) begin
        res = {1'b1, IDX_W'(i)};
      end
    end
    return res;
  endfunction

  // Configuration registers.
  logic                ready_r;
  logic [MTYPE_W-1:0]  default_type_r;
  logic [RANGES_W-1:0] ranges_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r        <= 1'b0;
      default_type_r <= DEFAULT_TYPE_RST;
      ranges_r       <= RANGES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_READY:        ready_r        <= cfg_wdata[0];
        CFG_DEFAULT_TYPE: default_type_r <= cfg_wdata;
        CFG_RANGES:       ranges_r       <= cfg_wdata[RANGES_W-1:0];
        default:          ready_r        <= ready_r;
      endcase
    end
  end

  // Request capture. The set parameter checks are settled here so that the
  // execute cycle only has the table search.
  logic [1:0]           op_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [ETYPE_W-1:0]   type_r;
  logic [LOG2_W-1:0]    log2_r;
  logic                 set_ok_r;

  logic [SIZE_BITS-1:0] size_m1;
  logic                 size_pow2;
  logic                 size_ge_min;
  logic                 size_le_max;
  logic                 base_aligned;
  logic                 type_ok;
  logic [LOG2_W-1:0]    log2_in;

  always_comb begin
    size_m1      = in_size - SIZE_BITS'(1);
    size_pow2    = (in_size != '0) && ((in_size & size_m1) == '0);
    size_ge_min  = |in_size[SIZE_BITS-1:MIN_SIZE_LOG2];
    size_le_max  = in_size <= (SIZE_BITS'(1) << ADDR_BITS);
    base_aligned = (in_address & size_m1[ADDR_BITS-1:0]) == '0;
    type_ok      = in_mem_type <= TYPE_MAX;
    log2_in      = '0;
    for (int k = 0; k < SIZE_BITS; k++) begin
      if (in_size[k]) begin
        log2_in = log2_in | LOG2_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= in_op;
      addr_r   <= in_address;
      type_r   <= in_mem_type[ETYPE_W-1:0];
      log2_r   <= log2_in;
      set_ok_r <= type_ok && size_pow2 && size_ge_min && size_le_max && base_aligned;
    end
  end

  // Range table.
  logic [NUM_RANGES-1:0] entry_valid_r;
  logic [ADDR_BITS-1:0]  entry_base_r [NUM_RANGES];
  logic [LOG2_W-1:0]     entry_log2_r [NUM_RANGES];
  logic [ETYPE_W-1:0]    entry_type_r [NUM_RANGES];

  logic [NUM_RANGES-1:0] free_hit;
  logic [NUM_RANGES-1:0] clr_hit;
  logic [NUM_RANGES-1:0] lk_hit;
  logic [ADDR_BITS-1:0]  range_mask [NUM_RANGES];

  // Entries are aligned to their size, so an address is inside a range when
  // it agrees with the base on every bit above the size.
  always_comb begin
    for (int i = 0; i < NUM_RANGES; i++) begin
      logic usable;
      usable        = i < int'(ranges_r);
      range_mask[i] = ~({ADDR_BITS{1'b1}} << entry_log2_r[i]);
      free_hit[i]   = usable && !entry_valid_r[i];
      clr_hit[i]    = usable && entry_valid_r[i] && (entry_base_r[i] == addr_r);
      lk_hit[i]     = usable && entry_valid_r[i] &&
                      (((addr_r ^ entry_base_r[i]) & ~range_mask[i]) == '0);
    end
  end

  logic [IDX_W:0] free_pick;
  logic [IDX_W:0] clr_pick;
  logic [IDX_W:0] lk_pick;

  assign free_pick = pick_first(free_hit);
  assign clr_pick  = pick_first(clr_hit);
  assign lk_pick   = pick_first(lk_hit);

  status_t             status_nxt;
  logic [MTYPE_W-1:0]  found_type_nxt;
  logic [SLOT_W-1:0]   slot_nxt;
  logic                do_write;
  logic                do_free;

  always_comb begin
    status_nxt     = ST_OK;
    found_type_nxt = '0;
    slot_nxt       = '0;
    do_write       = 1'b0;
    do_free        = 1'b0;
    case (op_r)
      OP_SET: begin
        if (!ready_r) begin
          status_nxt = ST_NOT_READY;
        end else if (!set_ok_r) begin
          status_nxt = ST_BAD_PARAM;
        end else if (free_pick[IDX_W]) begin
          slot_nxt = SLOT_W'(free_pick[IDX_W-1:0]);
          do_write = 1'b1;
        end else begin
          status_nxt = ST_NO_SLOT;
        end
      end
      OP_CLEAR: begin
        if (clr_pick[IDX_W]) begin
          slot_nxt = SLOT_W'(clr_pick[IDX_W-1:0]);
          do_free  = 1'b1;
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      OP_LOOKUP: begin
        if (!ready_r) begin
          status_nxt = ST_NOT_READY;
        end else if (lk_pick[IDX_W]) begin
          found_type_nxt = MTYPE_W'(entry_type_r[lk_pick[IDX_W-1:0]]);
          slot_nxt       = SLOT_W'(lk_pick[IDX_W-1:0]);
        end else begin
          found_type_nxt = default_type_r;
        end
      end
      default: begin
        status_nxt = ST_BAD_PARAM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
    end else if (cmd.execute) begin
      if (do_write) begin
        entry_valid_r[free_pick[IDX_W-1:0]] <= 1'b1;
      end else if (do_free) begin
        entry_valid_r[clr_pick[IDX_W-1:0]] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && do_write) begin
      entry_base_r[free_pick[IDX_W-1:0]] <= addr_r;
      entry_log2_r[free_pick[IDX_W-1:0]] <= log2_r;
      entry_type_r[free_pick[IDX_W-1:0]] <= type_r;
    end
  end

  // Result registers: out_valid_r is set in the cycle after execute, and the word stays until the next execute.
  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [MTYPE_W-1:0]  found_type_r;
  logic [SLOT_W-1:0]   slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.execute;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status_r     <= status_nxt;
      found_type_r <= found_type_nxt;
      slot_r       <= slot_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_found_type = found_type_r;
  assign out_slot       = slot_r;

  `MTRT_ASSERT_NXT(a_exec_gives_word, cmd.execute, out_valid_r,
    "execute did not produce a result word")
  `MTRT_ASSERT_IMP(a_type_only_lookup, out_valid_r && (op_r != OP_LOOKUP),
    found_type_r == '0, "nonzero type on a word that is not a lookup")
  `MTRT_ASSERT_IMP(a_fail_slot_zero, out_valid_r && (status_r != ST_OK),
    slot_r == '0, "failed operation reported a slot")

endmodule

// ===== rtl/memory_type_range_table.sv =====
// Top level of the memory type range table: controller plus datapath.
// Depends on mtrt_pkg, mtrt_ctrl and mtrt_dp.
//
//   Channel   Handshake            Ports
//   -------   ------------------   ---------------------------------------------
//   request   start & !busy        in_op, in_address, in_size, in_mem_type
//   result    out_valid (1 cycle)  out_status, out_found_type, out_slot
//   config    cfg_we               cfg_index, cfg_wdata
//
// Each word is first captured, with the set parameters checked, and then goes
// through the parallel comparison over all table entries.
// The result is on the out_ ports for the cycle after execute; a new word can
// be taken in that same cycle. busy is high during the execute cycle.
// Synchronous active-low reset clears the valid bits and loads the register
// defaults. The receiver cannot stall; results are never held.

module memory_type_range_table
  import mtrt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_op,
  input  logic [ADDR_BITS-1:0]  in_address,
  input  logic [SIZE_BITS-1:0]  in_size,
  input  logic [MTYPE_W-1:0]    in_mem_type,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic [MTYPE_W-1:0]    out_found_type,
  output logic [SLOT_W-1:0]     out_slot,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t cmd;

  mtrt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  mtrt_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_op          (in_op),
    .in_address     (in_address),
    .in_size        (in_size),
    .in_mem_type    (in_mem_type),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_found_type (out_found_type),
    .out_slot       (out_slot)
  );

endmodule
